[src/owbm_pkg.sv]
// Shared types and constants of the 1-Wire bus master.
package owbm_pkg;

   localparam int CfgWidth     = 12;
   localparam int NumCfg       = 8;
   localparam int BitsPerByte  = 8;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_RST_HIGH    = 4'd1,
      PH_RST_LOW     = 4'd2,
      PH_RST_WAIT    = 4'd3,
      PH_RST_RECOVER = 4'd4,
      PH_W_START     = 4'd5,
      PH_W_HOLD      = 4'd6,
      PH_W_RECOVER   = 4'd7,
      PH_R_START     = 4'd8,
      PH_R_WAIT      = 4'd9,
      PH_R_HOLD      = 4'd10,
      PH_R_RECOVER   = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_RESET = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CFG_RESET_HIGH    = 3'd0,
      CFG_RESET_LOW     = 3'd1,
      CFG_PRESENCE_WAIT = 3'd2,
      CFG_RESET_RECOVER = 3'd3,
      CFG_SLOT_START    = 3'd4,
      CFG_READ_SAMPLE   = 3'd5,
      CFG_SLOT_HOLD     = 3'd6,
      CFG_BIT_RECOVER   = 3'd7
   } cfg_index_type;

   typedef logic [NumCfg-1:0][CfgWidth-1:0] cfg_bank_type;

   // Highest index first.
   localparam cfg_bank_type CfgReset = {
      12'd2, 12'd40, 12'd3, 12'd2, 12'd100, 12'd40, 12'd500, 12'd50
   };

   typedef struct packed {
      phase_type  phase;
      logic [3:0] bit_index;
      logic [7:0] shift_byte;
      logic [7:0] last_read;
      logic       presence_bit;
      logic       finished;
   } ow_state_type;

   localparam ow_state_type StateReset = '{
      phase:        PH_IDLE,
      bit_index:    4'd0,
      shift_byte:   8'd0,
      last_read:    8'd0,
      presence_bit: 1'b1,
      finished:     1'b0
   };

endpackage

[src/owbm_step.sv]
// Per-tick next-state logic of the 1-Wire bus master, including the zero-length phase chain.
module owbm_step #(
   parameter int TIME_WIDTH = 12
) (
   input  owbm_pkg::cfg_bank_type  cfg,
   input  owbm_pkg::ow_state_type  state_q,
   input  logic [TIME_WIDTH-1:0]   tick_q,
   input  logic [1:0]              func,
   input  logic [7:0]              write_data,
   input  logic                    line_level,
   output owbm_pkg::ow_state_type  state_d,
   output logic [TIME_WIDTH-1:0]   tick_d,
   output logic                    drive_low
);

   // A non-degenerate phase chain passes at most four empty phases in one tick.
   localparam int SkipSteps = 4;

   function automatic logic [TIME_WIDTH-1:0] phase_len(owbm_pkg::phase_type ph,
                                                       owbm_pkg::cfg_bank_type c);
      logic [owbm_pkg::CfgWidth-1:0] r;
      unique case (ph)
         owbm_pkg::PH_RST_HIGH:    r = c[owbm_pkg::CFG_RESET_HIGH];
         owbm_pkg::PH_RST_LOW:     r = c[owbm_pkg::CFG_RESET_LOW];
         owbm_pkg::PH_RST_WAIT:    r = c[owbm_pkg::CFG_PRESENCE_WAIT];
         owbm_pkg::PH_RST_RECOVER: r = c[owbm_pkg::CFG_RESET_RECOVER];
         owbm_pkg::PH_W_START,
         owbm_pkg::PH_R_START:     r = c[owbm_pkg::CFG_SLOT_START];
         owbm_pkg::PH_R_WAIT:      r = c[owbm_pkg::CFG_READ_SAMPLE];
         owbm_pkg::PH_W_HOLD,
         owbm_pkg::PH_R_HOLD:      r = c[owbm_pkg::CFG_SLOT_HOLD];
         owbm_pkg::PH_W_RECOVER,
         owbm_pkg::PH_R_RECOVER:   r = c[owbm_pkg::CFG_BIT_RECOVER];
         default:                  r = '0;
      endcase
      return TIME_WIDTH'(r);
   endfunction

   function automatic owbm_pkg::ow_state_type leave_step(owbm_pkg::ow_state_type s,
                                                         logic lvl);
      owbm_pkg::ow_state_type n;
      n = s;
      n.phase = owbm_pkg::PH_IDLE;
      unique case (s.phase)
         owbm_pkg::PH_RST_HIGH: n.phase = owbm_pkg::PH_RST_LOW;
         owbm_pkg::PH_RST_LOW:  n.phase = owbm_pkg::PH_RST_WAIT;
         owbm_pkg::PH_RST_WAIT: begin
            n.presence_bit = lvl;
            n.phase        = owbm_pkg::PH_RST_RECOVER;
         end
         owbm_pkg::PH_RST_RECOVER: n.finished = 1'b1;
         owbm_pkg::PH_W_START:     n.phase = owbm_pkg::PH_W_HOLD;
         owbm_pkg::PH_W_HOLD:      n.phase = owbm_pkg::PH_W_RECOVER;
         owbm_pkg::PH_W_RECOVER: begin
            n.shift_byte = s.shift_byte >> 1;
            n.bit_index  = s.bit_index + 4'd1;
            if (n.bit_index >= 4'(owbm_pkg::BitsPerByte)) begin
               n.finished = 1'b1;
            end else begin
               n.phase = owbm_pkg::PH_W_START;
            end
         end
         owbm_pkg::PH_R_START: n.phase = owbm_pkg::PH_R_WAIT;
         owbm_pkg::PH_R_WAIT: begin
            n.shift_byte = {lvl, s.shift_byte[7:1]};
            n.phase      = owbm_pkg::PH_R_HOLD;
         end
         owbm_pkg::PH_R_HOLD: n.phase = owbm_pkg::PH_R_RECOVER;
         owbm_pkg::PH_R_RECOVER: begin
            n.bit_index = s.bit_index + 4'd1;
            if (n.bit_index >= 4'(owbm_pkg::BitsPerByte)) begin
               n.last_read = s.shift_byte;
               n.finished  = 1'b1;
            end else begin
               n.phase = owbm_pkg::PH_R_START;
            end
         end
         default: n.phase = owbm_pkg::PH_IDLE;
      endcase
      return n;
   endfunction

   // When every phase of a bit slot is empty, the rest of the byte runs out at once.
   function automatic owbm_pkg::ow_state_type finish_byte(owbm_pkg::ow_state_type s,
                                                          logic lvl, logic is_write);
      owbm_pkg::ow_state_type n;
      logic [3:0] remaining;
      logic [7:0] fill;
      n         = s;
      remaining = 4'(owbm_pkg::BitsPerByte) - s.bit_index;
      fill      = lvl ? (8'hFF << s.bit_index[2:0]) : 8'h00;
      n.phase     = owbm_pkg::PH_IDLE;
      n.finished  = 1'b1;
      n.bit_index = 4'(owbm_pkg::BitsPerByte);
      if (is_write) begin
         n.shift_byte = s.shift_byte >> remaining;
      end else begin
         n.shift_byte = (s.shift_byte >> remaining) | fill;
         n.last_read  = n.shift_byte;
      end
      return n;
   endfunction

   logic                   write_empty;
   logic                   read_empty;
   owbm_pkg::ow_state_type walk;
   logic                   restart;
   logic [TIME_WIDTH-1:0]  tick_next;

   assign write_empty = (phase_len(owbm_pkg::PH_W_START, cfg) == '0)
                     && (phase_len(owbm_pkg::PH_W_HOLD, cfg) == '0)
                     && (phase_len(owbm_pkg::PH_W_RECOVER, cfg) == '0);
   assign read_empty  = write_empty && (phase_len(owbm_pkg::PH_R_WAIT, cfg) == '0);

   // Next state.
   always_comb begin
      walk          = state_q;
      walk.finished = 1'b0;
      restart       = 1'b0;
      if (state_q.phase == owbm_pkg::PH_IDLE) begin
         if (func != owbm_pkg::FUNC_TICK) begin
            walk.bit_index = 4'd0;
            restart        = 1'b1;
            unique case (owbm_pkg::func_type'(func))
               owbm_pkg::FUNC_RESET: walk.phase = owbm_pkg::PH_RST_HIGH;
               owbm_pkg::FUNC_WRITE: begin
                  walk.shift_byte = write_data;
                  walk.phase      = owbm_pkg::PH_W_START;
               end
               owbm_pkg::FUNC_READ: begin
                  walk.shift_byte = 8'd0;
                  walk.phase      = owbm_pkg::PH_R_START;
               end
               default: walk.phase = owbm_pkg::PH_IDLE;
            endcase
         end
      end else if (tick_q >= phase_len(state_q.phase, cfg)) begin
         walk    = leave_step(walk, line_level);
         restart = 1'b1;
      end
      for (int i = 0; i < SkipSteps; i++) begin
         if (walk.phase != owbm_pkg::PH_IDLE && phase_len(walk.phase, cfg) == '0) begin
            if (walk.phase == owbm_pkg::PH_W_START && write_empty) begin
               walk = finish_byte(walk, line_level, 1'b1);
            end else if (walk.phase == owbm_pkg::PH_R_START && read_empty) begin
               walk = finish_byte(walk, line_level, 1'b0);
            end else begin
               walk = leave_step(walk, line_level);
            end
         end
      end
      tick_next = restart ? '0 : tick_q;
      if (walk.phase != owbm_pkg::PH_IDLE) begin
         tick_next = tick_next + 1'b1;
      end
      state_d = walk;
      tick_d  = tick_next;
   end

   // Line drive from the phase the tick ends in.
   always_comb begin
      unique case (state_d.phase)
         owbm_pkg::PH_RST_LOW,
         owbm_pkg::PH_W_START,
         owbm_pkg::PH_R_START: drive_low = 1'b1;
         owbm_pkg::PH_W_HOLD:  drive_low = ~state_d.shift_byte[0];
         default:              drive_low = 1'b0;
      endcase
   end

endmodule

[src/one_wire_bus_master_top.sv]
// Top level of the 1-Wire bus master: stream channels, register port and tick pipeline.
//
//  Channel | Direction | Transaction
//  req_    | in        | one time-base tick: func, write_data, line_level
//  rsp_    | out       | one result per tick: drive_low, busy, done, read_data, presence
//  csr_    | in        | APB write or read of one of eight 12-bit timing registers
//
// A tick is taken in every cycle while the result stream is not held back. An accepted
// tick is first held in the input register; its result is then loaded into the result register.
// Runs of empty phases are resolved within the step of a single tick.
// Reset is synchronous: phase idle, presence level high, timing registers to defaults.
// While rsp_tready is low the result is held and one further tick waits in the
// input register; req_tready then falls until the result is taken.
module one_wire_bus_master_top #(
   parameter int TIME_WIDTH = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] func, [9:2] write_data, [10] line_level, [15:11] zero
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data,
   // [11] presence_level, [15:12] zero
   output logic [15:0] rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [owbm_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [owbm_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [owbm_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   owbm_pkg::cfg_bank_type  cfg_ff, cfg_in;
   owbm_pkg::ow_state_type  state_ff, state_in;
   logic [TIME_WIDTH-1:0]   tick_ff, tick_in;
   logic                    in_valid_ff, in_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic [1:0]              in_func_ff;
   logic [7:0]              in_wdata_ff;
   logic                    in_level_ff;
   logic [15:0]             out_data_ff;
   logic                    advance;
   logic                    drive_low;
   logic [2:0]              csr_index;

   assign csr_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = owbm_pkg::CsrDataWidth'(cfg_ff[csr_index]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         cfg_in[csr_index] = csr_pwdata[owbm_pkg::CfgWidth-1:0];
      end
   end

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   owbm_pkg::ow_state_type step_state;
   logic [TIME_WIDTH-1:0]  step_tick;

   owbm_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .cfg        (cfg_ff),
      .state_q    (state_ff),
      .tick_q     (tick_ff),
      .func       (in_func_ff),
      .write_data (in_wdata_ff),
      .line_level (in_level_ff),
      .state_d    (step_state),
      .tick_d     (step_tick),
      .drive_low  (drive_low)
   );

   always_comb begin
      state_in = advance ? step_state : state_ff;
      tick_in  = advance ? step_tick : tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= owbm_pkg::CfgReset;
         state_ff     <= owbm_pkg::StateReset;
         tick_ff      <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff  <= req_tdata[1:0];
         in_wdata_ff <= req_tdata[9:2];
         in_level_ff <= req_tdata[10];
      end
      if (advance) begin
         out_data_ff <= {4'd0,
                         step_state.presence_bit,
                         step_state.last_read,
                         step_state.finished,
                         step_state.phase != owbm_pkg::PH_IDLE,
                         drive_low};
      end
   end

endmodule

[verif/one_wire_bus_master_top_tb.sv]
// Self-checking testbench for the 1-Wire bus master: tick stream, timing registers, result stream.
`timescale 1ns / 100ps

module one_wire_bus_master_top_tb;

   typedef struct packed {
      logic               line;
      logic [7:0]         wdata;
      owbm_pkg::func_type func;
   } bus_tick_type;

   typedef struct packed {
      logic       pres;
      logic [7:0] rdata;
      logic       done;
      logic       busy;
      logic       drive;
   } bus_result_type;

   localparam owbm_pkg::cfg_bank_type DEFAULT_TIMING = {
      12'd2, 12'd40, 12'd3, 12'd2, 12'd100, 12'd40, 12'd500, 12'd50
   };
   localparam owbm_pkg::cfg_bank_type SHORT_TIMING = {
      12'd1, 12'd2, 12'd1, 12'd1, 12'd1, 12'd2, 12'd3, 12'd2
   };
   localparam int LONG_HOLD_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [owbm_pkg::CsrAddrWidth-1:0]    csr_paddr = '0;
   logic [owbm_pkg::CsrDataWidth-1:0]    csr_pwdata = '0;
   logic [owbm_pkg::CsrDataWidth-1:0]    csr_prdata;
   logic                                 csr_pready;

   one_wire_bus_master_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #200_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Bus master model state and its copy of the timing registers.
   owbm_pkg::cfg_bank_type timing = DEFAULT_TIMING;
   owbm_pkg::phase_type    bus_phase = owbm_pkg::PH_IDLE;
   logic [11:0]  phase_ticks = '0;
   logic [3:0]   slot_index = '0;
   logic [7:0]   shift_reg = '0;
   logic [7:0]   byte_read = '0;
   logic         presence_seen = 1'b1;
   logic         op_complete = 1'b0;

   bus_tick_type   ticks_to_send[$];
   bus_result_type bus_results_due[$];
   int             mismatch_count = 0;
   int             sender_idle_pct = 9;
   int             receiver_idle_pct = 75;
   bit             tick_taken = 1'b0;
   bit             hold_req = 1'b0;
   bit             hold_done = 1'b0;
   int             hold_left = 0;

   function automatic logic [11:0] duration_of(owbm_pkg::phase_type ph);
      case (ph)
         owbm_pkg::PH_RST_HIGH:    return timing[owbm_pkg::CFG_RESET_HIGH];
         owbm_pkg::PH_RST_LOW:     return timing[owbm_pkg::CFG_RESET_LOW];
         owbm_pkg::PH_RST_WAIT:    return timing[owbm_pkg::CFG_PRESENCE_WAIT];
         owbm_pkg::PH_RST_RECOVER: return timing[owbm_pkg::CFG_RESET_RECOVER];
         owbm_pkg::PH_W_START,
         owbm_pkg::PH_R_START:     return timing[owbm_pkg::CFG_SLOT_START];
         owbm_pkg::PH_R_WAIT:      return timing[owbm_pkg::CFG_READ_SAMPLE];
         owbm_pkg::PH_W_HOLD,
         owbm_pkg::PH_R_HOLD:      return timing[owbm_pkg::CFG_SLOT_HOLD];
         owbm_pkg::PH_W_RECOVER,
         owbm_pkg::PH_R_RECOVER:   return timing[owbm_pkg::CFG_BIT_RECOVER];
         default:                  return 12'd0;
      endcase
   endfunction

   function automatic void end_phase(logic lvl);
      owbm_pkg::phase_type nx;
      nx = owbm_pkg::PH_IDLE;
      case (bus_phase)
         owbm_pkg::PH_RST_HIGH: nx = owbm_pkg::PH_RST_LOW;
         owbm_pkg::PH_RST_LOW:  nx = owbm_pkg::PH_RST_WAIT;
         owbm_pkg::PH_RST_WAIT: begin
            presence_seen = lvl;
            nx = owbm_pkg::PH_RST_RECOVER;
         end
         owbm_pkg::PH_RST_RECOVER: op_complete = 1'b1;
         owbm_pkg::PH_W_START:  nx = owbm_pkg::PH_W_HOLD;
         owbm_pkg::PH_W_HOLD:   nx = owbm_pkg::PH_W_RECOVER;
         owbm_pkg::PH_W_RECOVER: begin
            shift_reg = shift_reg >> 1;
            slot_index = slot_index + 4'd1;
            if (slot_index >= 4'd8) op_complete = 1'b1;
            else nx = owbm_pkg::PH_W_START;
         end
         owbm_pkg::PH_R_START:  nx = owbm_pkg::PH_R_WAIT;
         owbm_pkg::PH_R_WAIT: begin
            shift_reg = {lvl, shift_reg[7:1]};
            nx = owbm_pkg::PH_R_HOLD;
         end
         owbm_pkg::PH_R_HOLD:   nx = owbm_pkg::PH_R_RECOVER;
         owbm_pkg::PH_R_RECOVER: begin
            slot_index = slot_index + 4'd1;
            if (slot_index >= 4'd8) begin
               byte_read = shift_reg;
               op_complete = 1'b1;
            end else nx = owbm_pkg::PH_R_START;
         end
         default: ;
      endcase
      bus_phase = nx;
      phase_ticks = '0;
   endfunction

   // Phases of zero length are passed through within the same tick.
   function automatic void skip_zero_phases(logic lvl);
      while (bus_phase != owbm_pkg::PH_IDLE && duration_of(bus_phase) == 12'd0)
         end_phase(lvl);
   endfunction

   function automatic bus_result_type advance_bus(bus_tick_type tk);
      bus_result_type res;
      op_complete = 1'b0;
      if (bus_phase == owbm_pkg::PH_IDLE) begin
         if (tk.func != owbm_pkg::FUNC_TICK) begin
            slot_index = '0;
            phase_ticks = '0;
            case (tk.func)
               owbm_pkg::FUNC_RESET: bus_phase = owbm_pkg::PH_RST_HIGH;
               owbm_pkg::FUNC_WRITE: begin
                  shift_reg = tk.wdata;
                  bus_phase = owbm_pkg::PH_W_START;
               end
               default: begin
                  shift_reg = '0;
                  bus_phase = owbm_pkg::PH_R_START;
               end
            endcase
            skip_zero_phases(tk.line);
            if (bus_phase != owbm_pkg::PH_IDLE) phase_ticks = 12'd1;
         end
      end else begin
         if (phase_ticks >= duration_of(bus_phase)) begin
            end_phase(tk.line);
            skip_zero_phases(tk.line);
         end
         if (bus_phase != owbm_pkg::PH_IDLE) phase_ticks = phase_ticks + 12'd1;
      end
      case (bus_phase)
         owbm_pkg::PH_RST_LOW,
         owbm_pkg::PH_W_START,
         owbm_pkg::PH_R_START: res.drive = 1'b1;
         owbm_pkg::PH_W_HOLD:  res.drive = ~shift_reg[0];
         default:              res.drive = 1'b0;
      endcase
      res.busy  = (bus_phase != owbm_pkg::PH_IDLE);
      res.done  = op_complete;
      res.rdata = byte_read;
      res.pres  = presence_seen;
      return res;
   endfunction

   function automatic void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   // Sender: the model advances on each accepted tick.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         bus_results_due.push_back(advance_bus(bus_tick_type'(req_tdata[10:0])));
         void'(ticks_to_send.pop_front());
         tick_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || tick_taken) begin
         tick_taken = 1'b0;
         if (ticks_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {5'b0, ticks_to_send[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver, with one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      bus_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (bus_results_due.size() == 0) begin
            $error("result transaction with no tick outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            exp_res = bus_results_due.pop_front();
            check_field("drive_low", int'(exp_res.drive), int'(rsp_tdata[0]));
            check_field("busy_res", int'(exp_res.busy), int'(rsp_tdata[1]));
            check_field("done_res", int'(exp_res.done), int'(rsp_tdata[2]));
            check_field("read_data", int'(exp_res.rdata), int'(rsp_tdata[10:3]));
            check_field("presence_level", int'(exp_res.pres), int'(rsp_tdata[11]));
         end
      end
   end

   task automatic queue_tick(owbm_pkg::func_type f, logic [7:0] wd, logic lvl);
      ticks_to_send.push_back('{line: lvl, wdata: wd, func: f});
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (ticks_to_send.size() != 0 || bus_results_due.size() != 0);
   endtask

   // Level 0 or 1 holds the line there; anything else gives a random line.
   task automatic run_until_idle(int level);
      do begin
         repeat (32) begin
            queue_tick(owbm_pkg::FUNC_TICK, 8'($urandom),
                       (level == 0) ? 1'b0 : (level == 1) ? 1'b1 : 1'($urandom));
         end
         wait_drained();
      end while (bus_phase != owbm_pkg::PH_IDLE);
   endtask

   task automatic csr_transfer(logic wr, owbm_pkg::cfg_index_type idx, logic [11:0] wval,
                               output logic [owbm_pkg::CsrDataWidth-1:0] rval);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= owbm_pkg::CsrDataWidth'(wval);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      rval = csr_prdata;
      if (wr) timing[idx] = wval;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_timings(owbm_pkg::cfg_bank_type bank);
      logic [owbm_pkg::CsrDataWidth-1:0] rval;
      wait_drained();
      for (int i = 0; i < owbm_pkg::NumCfg; i++) begin
         csr_transfer(1'b1, owbm_pkg::cfg_index_type'(i), bank[i], rval);
         csr_transfer(1'b0, owbm_pkg::cfg_index_type'(i), '0, rval);
         check_field("timing register", int'(bank[i]), int'(rval));
      end
   endtask

   // Mostly very short phases, so that many operations fit in the run.
   function automatic owbm_pkg::cfg_bank_type random_timings();
      owbm_pkg::cfg_bank_type bank;
      for (int i = 0; i < owbm_pkg::NumCfg; i++) begin
         bank[i] = ($urandom_range(9) == 0) ? 12'($urandom_range(7, 20))
                                            : 12'($urandom_range(0, 4));
      end
      return bank;
   endfunction

   task automatic random_ticks(int count);
      owbm_pkg::func_type f;
      repeat (count) begin
         f = ($urandom_range(99) < 76) ? owbm_pkg::FUNC_TICK
                                       : owbm_pkg::func_type'($urandom_range(1, 3));
         queue_tick(f, 8'($urandom), 1'($urandom));
      end
   endtask

   initial begin : stimulus
      logic [owbm_pkg::CsrDataWidth-1:0] rval;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < owbm_pkg::NumCfg; i++) begin
         csr_transfer(1'b0, owbm_pkg::cfg_index_type'(i), '0, rval);
         check_field("timing register after reset", int'(DEFAULT_TIMING[i]), int'(rval));
      end
      queue_tick(owbm_pkg::FUNC_READ, 8'h00, 1'b1);
      run_until_idle(2);

      set_timings(SHORT_TIMING);
      queue_tick(owbm_pkg::FUNC_RESET, 8'h00, 1'b0);
      run_until_idle(0);
      queue_tick(owbm_pkg::FUNC_RESET, 8'hFF, 1'b1);
      run_until_idle(1);
      queue_tick(owbm_pkg::FUNC_WRITE, 8'h00, 1'b1);
      run_until_idle(2);
      queue_tick(owbm_pkg::FUNC_WRITE, 8'hFF, 1'b0);
      run_until_idle(2);
      // Commands offered while the write is in progress must be ignored.
      queue_tick(owbm_pkg::FUNC_WRITE, 8'hA5, 1'b1);
      queue_tick(owbm_pkg::FUNC_READ, 8'h3C, 1'b0);
      queue_tick(owbm_pkg::FUNC_RESET, 8'hC3, 1'b1);
      queue_tick(owbm_pkg::FUNC_WRITE, 8'h5A, 1'b0);
      run_until_idle(2);
      queue_tick(owbm_pkg::FUNC_READ, 8'h00, 1'b1);
      run_until_idle(1);
      queue_tick(owbm_pkg::FUNC_READ, 8'hFF, 1'b0);
      run_until_idle(0);

      // With every phase empty each operation completes on the tick that starts it.
      set_timings('0);
      queue_tick(owbm_pkg::FUNC_RESET, 8'h00, 1'b0);
      queue_tick(owbm_pkg::FUNC_RESET, 8'h00, 1'b1);
      queue_tick(owbm_pkg::FUNC_WRITE, 8'h5A, 1'b1);
      queue_tick(owbm_pkg::FUNC_READ, 8'hFF, 1'b1);
      queue_tick(owbm_pkg::FUNC_READ, 8'h00, 1'b0);
      queue_tick(owbm_pkg::FUNC_TICK, 8'hFF, 1'b1);
      wait_drained();

      for (int chunk = 0; chunk < 6; chunk++) begin
         set_timings(random_timings());
         sender_idle_pct   = (chunk < 2) ? 9 : (chunk < 4) ? 75 : 0;
         receiver_idle_pct = (chunk < 2) ? 75 : (chunk < 4) ? 9 : 0;
         random_ticks(180);
         if (chunk == 4) begin
            @(posedge clock);
            hold_req = 1'b1;
         end
      end

      // Full-scale register values are checked by read-back only, as a slot at full
      // length is very slow.
      set_timings({owbm_pkg::NumCfg{12'hFFF}});

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

[one_wire_bus_master_top.f]
src/owbm_pkg.sv
src/owbm_step.sv
src/one_wire_bus_master_top.sv
verif/one_wire_bus_master_top_tb.sv
